/* rtl/wfr_pkg.sv */
// Package for the WebSocket frame receiver: result type, opcode and kind codes,
// and the reset value of the payload length cap. Depends on nothing.
package wfr_pkg;

    localparam int unsigned LEN_W = 25;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 25'd16777216;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_PING  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        t_kind      kind;
        logic       last;
    } t_result;

endpackage

/* rtl/websocket_frame_receiver_unit.sv */
// Top level of the WebSocket frame receiver: input register, parser, result buffer
// and the payload length cap. Depends on wfr_pkg, wfr_parser and wfr_out_queue.
//
// Usage: the input channel carries one byte of an established session's frame
// stream per beat (i_in_rx_byte, plus i_in_session_start to restart the parser
// as at a new connection). Each beat yields zero or one result on the output
// channel: an unmasked text or ping payload byte, an empty-frame marker, a
// close-reply request, or a length error. The user must write the length cap
// through i_cfg_wr_en / i_cfg_wr_data while the block is idle; the block does not enforce it.
// Results are registered: the accepting edge loads the input register, and once
// the buffer has a free entry the beat passes through the parser into the buffer.
// The parser takes one beat per cycle while the buffer has a free entry.
// When the output is stalled, results collect in a two-entry buffer; once both
// entries hold results and a beat waits in the input register, o_in_stall rises
// and the input register holds its beat until the buffer drains. o_in_stall
// comes from registers only.
// Reset (synchronous, active low) clears the parser to wait for the first
// header byte, empties both the input register and the buffer, and sets the
// length cap to 16777216.
module websocket_frame_receiver_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [wfr_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_in_rx_byte,
    input  logic                      i_in_session_start,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_out_data_byte,
    output logic                      o_out_has_data,
    output logic [1:0]                o_out_kind,
    output logic                      o_out_last
);

    logic [wfr_pkg::LEN_W-1:0] r_max_len;
    logic                      r_in_vld;
    logic [7:0]                r_in_byte;
    logic                      r_in_start;

    logic                      in_accept;
    logic                      advance;
    logic                      q_full;
    logic                      res_valid;
    wfr_pkg::t_result          res;
    wfr_pkg::t_result          out_res;

    // The parser moves a beat on whenever the buffer has a free entry, whether or
    // not that beat produces a result.
    assign advance    = r_in_vld && !q_full;
    assign o_in_stall = r_in_vld && q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= wfr_pkg::MAX_LEN_RESET;
            r_in_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
        end
        if (in_accept) begin
            r_in_byte  <= i_in_rx_byte;
            r_in_start <= i_in_session_start;
        end
    end

    wfr_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_rx_byte       (r_in_byte),
        .i_session_start (r_in_start),
        .i_max_len       (r_max_len),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    wfr_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (advance && res_valid),
        .i_push_res (res),
        .i_stall    (i_out_stall),
        .o_full     (q_full),
        .o_valid    (o_out_valid),
        .o_res      (out_res)
    );

    assign o_out_data_byte = out_res.data_byte;
    assign o_out_has_data  = out_res.has_data;
    assign o_out_kind      = out_res.kind;
    assign o_out_last      = out_res.last;

endmodule

/* rtl/wfr_parser.sv */
// Frame header decoder and payload unmasker; updates its state once per beat.
// Depends on wfr_pkg.
module wfr_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       i_session_start,
    input  logic [wfr_pkg::LEN_W-1:0]  i_max_len,
    output logic                       o_res_valid,
    output wfr_pkg::t_result           o_res
);

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_MASK = 6'b001000,
        PH_DATA = 6'b010000,
        PH_DEAD = 6'b100000
    } t_phase;

    t_phase                    r_phase, n_phase;
    logic [3:0]                r_opcode, n_opcode;
    logic                      r_masked, n_masked;
    logic [2:0]                r_ext_left, n_ext_left;
    logic [wfr_pkg::LEN_W-1:0] r_acc, n_acc;
    logic                      r_acc_hi, n_acc_hi;
    logic [31:0]               r_key, n_key;
    logic [1:0]                r_mask_left, n_mask_left;
    logic [wfr_pkg::LEN_W-1:0] r_remain, n_remain;
    logic [1:0]                r_key_idx, n_key_idx;

    t_phase                    ph;
    logic [6:0]                len7;
    logic                      len_go, len_hi, len_masked;
    logic [wfr_pkg::LEN_W-1:0] len_val;
    logic                      begin_go;
    logic [wfr_pkg::LEN_W-1:0] begin_len;
    logic [wfr_pkg::LEN_W-1:0] acc_sh, remain_dec;
    logic [7:0]                key_byte;
    logic                      data_last;

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_ext_left  = r_ext_left;
        n_acc       = r_acc;
        n_acc_hi    = r_acc_hi;
        n_key       = r_key;
        n_mask_left = r_mask_left;
        n_remain    = r_remain;
        n_key_idx   = r_key_idx;
        o_res_valid = 1'b0;
        o_res       = '0;
        len_go      = 1'b0;
        len_hi      = 1'b0;
        len_masked  = 1'b0;
        len_val     = '0;
        begin_go    = 1'b0;
        begin_len   = '0;
        len7        = i_rx_byte[6:0];
        acc_sh      = {r_acc[wfr_pkg::LEN_W-9:0], i_rx_byte};
        remain_dec  = r_remain - wfr_pkg::LEN_W'(1);
        data_last   = (remain_dec == '0);
        key_byte    = 8'd0;
        ph          = i_session_start ? PH_HDR0 : r_phase;

        // A session start drops everything the parser holds before the beat is taken.
        if (i_session_start) begin
            n_opcode    = '0;
            n_masked    = 1'b0;
            n_ext_left  = '0;
            n_acc       = '0;
            n_acc_hi    = 1'b0;
            n_key       = '0;
            n_mask_left = '0;
            n_remain    = '0;
            n_key_idx   = '0;
        end

        case (ph)
            PH_DEAD: begin
            end
            PH_HDR1: begin
                n_masked = i_rx_byte[7];
                n_key    = '0;
                if (len7 == wfr_pkg::LEN7_EXT16 || len7 == wfr_pkg::LEN7_EXT64) begin
                    n_ext_left = (len7 == wfr_pkg::LEN7_EXT16) ? 3'd1 : 3'd7;
                    n_acc      = '0;
                    n_acc_hi   = 1'b0;
                    n_phase    = PH_EXT;
                end else begin
                    len_go     = 1'b1;
                    len_val    = wfr_pkg::LEN_W'(len7);
                    len_masked = i_rx_byte[7];
                end
            end
            PH_EXT: begin
                // Only the low bits are kept; anything shifted above them marks the
                // length as beyond any cap.
                n_acc    = acc_sh;
                n_acc_hi = r_acc_hi | (r_acc[wfr_pkg::LEN_W-1:wfr_pkg::LEN_W-8] != 8'd0);
                if (r_ext_left == 3'd0) begin
                    len_go     = 1'b1;
                    len_val    = acc_sh;
                    len_hi     = n_acc_hi;
                    len_masked = r_masked;
                end else begin
                    n_ext_left = r_ext_left - 3'd1;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], i_rx_byte};
                if (r_mask_left == 2'd0) begin
                    begin_go  = 1'b1;
                    begin_len = r_remain;
                end else begin
                    n_mask_left = r_mask_left - 2'd1;
                end
            end
            PH_DATA: begin
                case (r_key_idx)
                    2'd0:    key_byte = r_key[31:24];
                    2'd1:    key_byte = r_key[23:16];
                    2'd2:    key_byte = r_key[15:8];
                    default: key_byte = r_key[7:0];
                endcase
                n_key_idx = r_key_idx + 2'd1;
                n_remain  = remain_dec;
                if (data_last) begin
                    n_phase = PH_HDR0;
                end
                if (r_opcode == wfr_pkg::OP_TEXT || r_opcode == wfr_pkg::OP_PING) begin
                    o_res_valid     = 1'b1;
                    o_res.data_byte = i_rx_byte ^ key_byte;
                    o_res.has_data  = 1'b1;
                    o_res.kind      = (r_opcode == wfr_pkg::OP_TEXT) ? wfr_pkg::KIND_TEXT
                                                                      : wfr_pkg::KIND_PING;
                    o_res.last      = data_last;
                end else if (r_opcode == wfr_pkg::OP_CLOSE && data_last) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = wfr_pkg::KIND_CLOSE;
                    o_res.last  = 1'b1;
                end
            end
            default: begin
                n_opcode = i_rx_byte[3:0];
                n_phase  = PH_HDR1;
            end
        endcase

        // The full length is known: check it against the cap, then go on to the key or
        // straight to the payload.
        if (len_go) begin
            if (len_hi || len_val > i_max_len) begin
                n_phase     = PH_DEAD;
                o_res_valid = 1'b1;
                o_res.kind  = wfr_pkg::KIND_ERROR;
                o_res.last  = 1'b1;
            end else begin
                n_remain = len_val;
                if (len_masked) begin
                    n_mask_left = 2'd3;
                    n_phase     = PH_MASK;
                end else begin
                    begin_go  = 1'b1;
                    begin_len = len_val;
                end
            end
        end

        // Header and key are complete. An empty text, ping or close frame ends here with a marker result.
        if (begin_go) begin
            n_key_idx = '0;
            if (begin_len != '0) begin
                n_phase = PH_DATA;
            end else begin
                n_phase = PH_HDR0;
                o_res.last = 1'b1;
                case (r_opcode)
                    wfr_pkg::OP_TEXT: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = wfr_pkg::KIND_TEXT;
                    end
                    wfr_pkg::OP_PING: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = wfr_pkg::KIND_PING;
                    end
                    wfr_pkg::OP_CLOSE: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = wfr_pkg::KIND_CLOSE;
                    end
                    default: begin
                        o_res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_opcode    <= '0;
            r_masked    <= 1'b0;
            r_ext_left  <= '0;
            r_acc       <= '0;
            r_acc_hi    <= 1'b0;
            r_key       <= '0;
            r_mask_left <= '0;
            r_remain    <= '0;
            r_key_idx   <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_masked    <= n_masked;
            r_ext_left  <= n_ext_left;
            r_acc       <= n_acc;
            r_acc_hi    <= n_acc_hi;
            r_key       <= n_key;
            r_mask_left <= n_mask_left;
            r_remain    <= n_remain;
            r_key_idx   <= n_key_idx;
        end
    end

endmodule

/* rtl/wfr_out_queue.sv */
// Two-entry result buffer: a result register backed by a skid register.
// Depends on wfr_pkg.
module wfr_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wfr_pkg::t_result i_push_res,
    input  logic             i_stall,
    output logic             o_full,
    output logic             o_valid,
    output wfr_pkg::t_result o_res
);

    logic             r_head_vld, n_head_vld;
    logic             r_skid_vld, n_skid_vld;
    wfr_pkg::t_result r_head, n_head;
    wfr_pkg::t_result r_skid, n_skid;
    logic             pop;

    assign pop     = r_head_vld && !i_stall;
    assign o_full  = r_skid_vld;
    assign o_valid = r_head_vld;
    assign o_res   = r_head;

    always_comb begin
        n_head_vld = r_head_vld;
        n_skid_vld = r_skid_vld;
        n_head     = r_head;
        n_skid     = r_skid;
        if (r_skid_vld) begin
            // Full: no push arrives; a pop moves the skid entry up.
            if (pop) begin
                n_head     = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (!r_head_vld || pop) begin
            n_head_vld = i_push;
            n_head     = i_push_res;
        end else if (i_push) begin
            n_skid_vld = 1'b1;
            n_skid     = i_push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_head_vld <= n_head_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_head <= n_head;
        r_skid <= n_skid;
    end

endmodule

/* rtl/wfr_checker.sv */
// Port-level checker for the WebSocket frame receiver, bound to the top level.
// Depends on wfr_pkg and websocket_frame_receiver_unit.
module wfr_port_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_data_byte,
    input logic       o_out_has_data,
    input logic [1:0] o_out_kind,
    input logic       o_out_last
);

    // Close requests and length errors always end their frame.
    a_ctrl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_kind == wfr_pkg::KIND_CLOSE || o_out_kind == wfr_pkg::KIND_ERROR)
        |-> o_out_last)
        else $error("close or error result without last");

    // A result without a payload byte carries a zero byte.
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_has_data |-> o_out_data_byte == 8'd0)
        else $error("data byte not zero on a marker result");

    // Only text and ping results carry payload bytes.
    a_data_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_has_data
        |-> (o_out_kind == wfr_pkg::KIND_TEXT || o_out_kind == wfr_pkg::KIND_PING))
        else $error("payload byte on a close or error result");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall
        |=> o_out_valid && $stable(o_out_data_byte) && $stable(o_out_has_data)
            && $stable(o_out_kind) && $stable(o_out_last))
        else $error("stalled result changed");

endmodule

bind websocket_frame_receiver_unit wfr_port_props u_wfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_data_byte (o_out_data_byte),
    .o_out_has_data  (o_out_has_data),
    .o_out_kind      (o_out_kind),
    .o_out_last      (o_out_last)
);

/* test/wfr_checker.sv */
// Checker for the WebSocket frame receiver: watches the length cap port and both
// channels, predicts every result beat and compares it. Depends on wfr_pkg.
module wfr_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [wfr_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [7:0]                i_in_rx_byte,
    input  logic                      i_in_session_start,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [7:0]                i_out_data_byte,
    input  logic                      i_out_has_data,
    input  logic [1:0]                i_out_kind,
    input  logic                      i_out_last,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4,
        PH_DEAD = 3'd5
    } t_phase;

    logic [wfr_pkg::LEN_W-1:0] len_cap = wfr_pkg::MAX_LEN_RESET;
    t_phase                    phase = PH_HDR0;
    logic [3:0]                opcode;
    logic                      masked;
    logic [2:0]                ext_left;
    logic [63:0]               len_acc;
    logic [31:0]               mask_key;
    logic [1:0]                key_left;
    logic [wfr_pkg::LEN_W-1:0] bytes_left;
    logic [1:0]                key_idx;

    wfr_pkg::t_result frame_results[$];
    wfr_pkg::t_result want;
    int               fails = 0;
    int               checked = 0;

    task automatic clear_parser();
        phase = PH_HDR0;
        opcode = '0;
        masked = 1'b0;
        ext_left = '0;
        len_acc = '0;
        mask_key = '0;
        key_left = '0;
        bytes_left = '0;
        key_idx = '0;
    endtask

    task automatic push_result(input logic [7:0] d, input logic has,
                               input wfr_pkg::t_kind k, input logic fin);
        wfr_pkg::t_result r;
        r.data_byte = d;
        r.has_data = has;
        r.kind = k;
        r.last = fin;
        frame_results = {frame_results, r};
    endtask

    // Header and key are complete: either open the payload or close an empty frame.
    task automatic start_payload();
        key_idx = '0;
        if (bytes_left != '0) begin
            phase = PH_DATA;
        end else begin
            phase = PH_HDR0;
            if (opcode == wfr_pkg::OP_TEXT)
                push_result(8'h00, 1'b0, wfr_pkg::KIND_TEXT, 1'b1);
            else if (opcode == wfr_pkg::OP_PING)
                push_result(8'h00, 1'b0, wfr_pkg::KIND_PING, 1'b1);
            else if (opcode == wfr_pkg::OP_CLOSE)
                push_result(8'h00, 1'b0, wfr_pkg::KIND_CLOSE, 1'b1);
        end
    endtask

    task automatic length_done(input logic [63:0] len);
        if (len > {39'd0, len_cap}) begin
            phase = PH_DEAD;
            push_result(8'h00, 1'b0, wfr_pkg::KIND_ERROR, 1'b1);
        end else begin
            bytes_left = len[wfr_pkg::LEN_W-1:0];
            if (masked) begin
                key_left = 2'd3;
                phase = PH_MASK;
            end else begin
                start_payload();
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic restart);
        logic [6:0] len7;
        logic [7:0] d;
        logic       frame_done;
        if (restart) clear_parser();
        case (phase)
            PH_DEAD: begin
            end
            PH_HDR1: begin
                masked = b[7];
                mask_key = '0;
                len7 = b[6:0];
                if (len7 == wfr_pkg::LEN7_EXT16 || len7 == wfr_pkg::LEN7_EXT64) begin
                    ext_left = (len7 == wfr_pkg::LEN7_EXT16) ? 3'd1 : 3'd7;
                    len_acc = '0;
                    phase = PH_EXT;
                end else begin
                    length_done({57'd0, len7});
                end
            end
            PH_EXT: begin
                len_acc = {len_acc[55:0], b};
                if (ext_left == '0) length_done(len_acc);
                else ext_left = ext_left - 3'd1;
            end
            PH_MASK: begin
                mask_key = {mask_key[23:0], b};
                if (key_left == '0) start_payload();
                else key_left = key_left - 2'd1;
            end
            PH_DATA: begin
                d = b ^ mask_key[8*(3-key_idx) +: 8];
                key_idx = key_idx + 2'd1;
                bytes_left = bytes_left - wfr_pkg::LEN_W'(1);
                frame_done = (bytes_left == '0);
                if (frame_done) phase = PH_HDR0;
                if (opcode == wfr_pkg::OP_TEXT)
                    push_result(d, 1'b1, wfr_pkg::KIND_TEXT, frame_done);
                else if (opcode == wfr_pkg::OP_PING)
                    push_result(d, 1'b1, wfr_pkg::KIND_PING, frame_done);
                else if (opcode == wfr_pkg::OP_CLOSE && frame_done)
                    push_result(8'h00, 1'b0, wfr_pkg::KIND_CLOSE, 1'b1);
            end
            default: begin
                opcode = b[3:0];
                phase = PH_HDR1;
            end
        endcase
    endtask

    // Inputs are sampled before the edge updates them, so each edge sees one
    // settled view of both channels.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_cap = wfr_pkg::MAX_LEN_RESET;
            clear_parser();
            frame_results.delete();
        end else begin
            if (i_cfg_wr_en) len_cap = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) decode_byte(i_in_rx_byte, i_in_session_start);
            if (i_out_valid && !i_out_stall) begin
                if (frame_results.size() == 0) begin
                    $error("unexpected result: data_byte %0h has_data %0b kind %0d last %0b",
                           i_out_data_byte, i_out_has_data, i_out_kind, i_out_last);
                    fails++;
                end else begin
                    want = frame_results.pop_front();
                    checked++;
                    if (i_out_data_byte !== want.data_byte) begin
                        $error("data_byte: expected %0h, got %0h",
                               want.data_byte, i_out_data_byte);
                        fails++;
                    end
                    if (i_out_has_data !== want.has_data) begin
                        $error("has_data: expected %0b, got %0b",
                               want.has_data, i_out_has_data);
                        fails++;
                    end
                    if (i_out_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_out_kind);
                        fails++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_out_last);
                        fails++;
                    end
                end
            end
        end
        o_pending <= frame_results.size();
        o_fail_count <= fails;
        o_checked <= checked;
    end

endmodule

/* test/tb.sv */
// Testbench top for the WebSocket frame receiver: drives frame byte streams, length
// cap writes and output stalls, and gives the verdict. Depends on wfr_pkg,
// wfr_checker and websocket_frame_receiver_unit.
module tb;

    // An opcode that the block has no special handling for, used to show it drops out.
    localparam logic [3:0] OP_PONG = 4'hA;

    // How the payload length is carried in the header.
    typedef enum int {
        FORM_LEN7,
        FORM_LEN16,
        FORM_LEN64
    } t_len_form;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [wfr_pkg::LEN_W-1:0] cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [7:0]                in_rx_byte = '0;
    logic                      in_session_start = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [7:0]                out_data_byte;
    logic                      out_has_data;
    logic [1:0]                out_kind;
    logic                      out_last;

    int fail_count;
    int pending;
    int checked;

    // Idle rates in percent for the sender and the receiver, set per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The long receiver hold-off is started by the stimulus and timed by its own process.
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;

    int                        beat_count = 0;
    int                        frame_count = 0;
    logic [wfr_pkg::LEN_W-1:0] cap_now = wfr_pkg::MAX_LEN_RESET;

    // Set when the parser may be out of step with the frames the testbench sends
    // (after an over-cap abort, a cut-short frame or noise); the next frame should
    // then carry a session start.
    logic resync_due = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    websocket_frame_receiver_unit u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_in_rx_byte       (in_rx_byte),
        .i_in_session_start (in_session_start),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_out_data_byte    (out_data_byte),
        .o_out_has_data     (out_has_data),
        .o_out_kind         (out_kind),
        .o_out_last         (out_last)
    );

    wfr_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_in_rx_byte       (in_rx_byte),
        .i_in_session_start (in_session_start),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_out_data_byte    (out_data_byte),
        .i_out_has_data     (out_has_data),
        .i_out_kind         (out_kind),
        .i_out_last         (out_last),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    // The receiver stalls at random at the current rate, and solidly during the hold-off.
    always @(posedge clk) begin
        out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end

    // Long hold-off: the receiver refuses results while the sender keeps offering
    // beats, so the result buffer fills and the input stalls.
    initial begin : receiver_holdoff
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Offers one beat, after a random number of idle cycles, and returns at the edge
    // where it is accepted. The payload holds steady while the block stalls.
    task automatic send_beat(input logic [7:0] b, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_rx_byte <= b;
        in_session_start <= restart;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beat_count++;
    endtask

    // Sends one frame: header, extended length if the form asks, mask key if masked,
    // then n_data random payload bytes. A frame may be cut short by sending fewer
    // payload bytes than its length says.
    task automatic send_frame(input logic [3:0] op, input logic [63:0] len,
                              input t_len_form form, input logic masked,
                              input int n_data, input logic restart);
        logic [7:0] b;
        logic [6:0] len7;
        int         i;
        // FIN and the reserved bits are random; the block ignores them.
        b = 8'($urandom_range(255));
        b[3:0] = op;
        send_beat(b, restart);
        case (form)
            FORM_LEN16: len7 = wfr_pkg::LEN7_EXT16;
            FORM_LEN64: len7 = wfr_pkg::LEN7_EXT64;
            default:    len7 = len[6:0];
        endcase
        send_beat({masked, len7}, 1'b0);
        if (form == FORM_LEN16) begin
            send_beat(len[15:8], 1'b0);
            send_beat(len[7:0], 1'b0);
        end
        if (form == FORM_LEN64) begin
            for (i = 7; i >= 0; i--) send_beat(len[8*i +: 8], 1'b0);
        end
        if (masked) repeat (4) send_beat(8'($urandom_range(255)), 1'b0);
        repeat (n_data) send_beat(8'($urandom_range(255)), 1'b0);
        frame_count++;
    endtask

    // One well-formed frame with random content. Most are short text or ping frames;
    // some are close or other opcodes, some use long length forms or go over the cap,
    // and a few are cut short and usually followed by a restart.
    task automatic random_frame();
        int          pick;
        logic [3:0]  op;
        t_len_form   form;
        logic [63:0] len;
        logic        masked;
        logic        restart;
        int          n_data;
        pick = $urandom_range(99);
        if (pick < 40) op = wfr_pkg::OP_TEXT;
        else if (pick < 62) op = wfr_pkg::OP_PING;
        else if (pick < 75) op = wfr_pkg::OP_CLOSE;
        else op = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 60) form = FORM_LEN7;
        else if (pick < 85) form = FORM_LEN16;
        else form = FORM_LEN64;
        len = ($urandom_range(9) == 0) ? 64'($urandom_range(60, 13))
                                       : 64'($urandom_range(12));
        if (form == FORM_LEN16 && $urandom_range(7) == 0) len = 64'($urandom_range(65535));
        if (form == FORM_LEN64 && $urandom_range(3) == 0) len = {$urandom, $urandom};
        // Lengths right around the largest cap, on both sides of it.
        if (form == FORM_LEN64 && $urandom_range(5) == 0)
            len = 64'($urandom_range(16777220, 16777200));
        masked = 1'($urandom_range(1));
        restart = resync_due ? ($urandom_range(9) != 0) : ($urandom_range(24) == 0);
        if (restart) resync_due = 1'b0;
        if (len > {39'd0, cap_now}) begin
            n_data = 0;
            resync_due = 1'b1;
        end else if (len > 60 || $urandom_range(19) == 0) begin
            n_data = (len == 0) ? 0 : $urandom_range((len > 6) ? 5 : int'(len) - 1);
            if (len != 0) resync_due = 1'b1;
        end else begin
            n_data = int'(len);
        end
        send_frame(op, len, form, masked, n_data, restart);
    endtask

    task automatic run_segment(input int target);
        int stop_at;
        stop_at = beat_count + target;
        while (beat_count < stop_at) begin
            if ($urandom_range(24) == 0) begin
                // Noise: a few random bytes, now and then flagged as a session start.
                repeat ($urandom_range(4, 1)) send_beat(8'($urandom_range(255)),
                                                        $urandom_range(3) == 0);
                resync_due = 1'b1;
            end else begin
                random_frame();
            end
        end
    endtask

    // The sender pauses until every expected result has come out, then lets the
    // pipeline empty of beats that produce nothing.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cap(input logic [wfr_pkg::LEN_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_now = value;
    endtask

    initial begin : stimulus
        int                        seg;
        logic [wfr_pkg::LEN_W-1:0] caps [6];
        // Cap settings per phase: both extremes, small caps that trip often, and
        // random ones.
        caps[0] = wfr_pkg::MAX_LEN_RESET;
        caps[1] = '0;
        caps[2] = wfr_pkg::LEN_W'(9);
        caps[3] = wfr_pkg::LEN_W'($urandom_range(60, 1));
        caps[4] = wfr_pkg::LEN_W'($urandom_range(16777216));
        caps[5] = wfr_pkg::LEN_W'(125);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run at the reset cap with no idling.
        // An empty text frame gives a single marker; the session start on a
        // fresh parser changes nothing.
        send_frame(wfr_pkg::OP_TEXT, 64'd0, FORM_LEN7, 1'b0, 0, 1'b1);
        send_frame(wfr_pkg::OP_PING, 64'd2, FORM_LEN7, 1'b1, 2, 1'b0);
        send_frame(wfr_pkg::OP_TEXT, 64'd3, FORM_LEN16, 1'b1, 3, 1'b0);
        // A close frame reports once at its end, with or without payload.
        send_frame(wfr_pkg::OP_CLOSE, 64'd1, FORM_LEN7, 1'b0, 1, 1'b0);
        send_frame(wfr_pkg::OP_CLOSE, 64'd0, FORM_LEN7, 1'b0, 0, 1'b0);
        // A pong is consumed without any result.
        send_frame(OP_PONG, 64'd1, FORM_LEN7, 1'b0, 1, 1'b0);
        // A length exactly at the cap is accepted; the frame is then dropped by a
        // session start in mid payload, on a frame one byte over the cap.
        send_frame(wfr_pkg::OP_TEXT, 64'd16777216, FORM_LEN64, 1'b0, 1, 1'b0);
        send_frame(wfr_pkg::OP_TEXT, 64'd16777217, FORM_LEN64, 1'b0, 0, 1'b1);
        // While aborted every beat is ignored until a session start.
        send_beat(8'hFF, 1'b0);
        send_frame(wfr_pkg::OP_PING, 64'd0, FORM_LEN7, 1'b0, 0, 1'b1);
        drain();

        for (seg = 0; seg < 6; seg++) begin
            if (seg < 2) begin
                send_idle_pct = 14;
                recv_idle_pct = 57;
            end else if (seg < 4) begin
                send_idle_pct = 57;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_cap(caps[seg]);
            if (seg == 5) begin
                // A long text frame sent straight into the receiver hold-off.
                hold_go = 1'b1;
                send_frame(wfr_pkg::OP_TEXT, 64'd40, FORM_LEN7, 1'b1, 40, 1'b1);
                resync_due = 1'b0;
            end
            run_segment(165);
            drain();
        end

        $display("tb: %0d beats in %0d frames, %0d results compared",
                 beat_count, frame_count, checked);
        $display("tb: caps 0 to %0d, all opcodes, over-cap aborts, restarts, output hold-off",
                 wfr_pkg::MAX_LEN_RESET);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // This limit lies far beyond the length of the whole run.
    initial begin : watchdog
        #2000000;
        $error("timed out with %0d results outstanding", pending);
        $display("tb: done, errors");
        $finish;
    end

endmodule
